FILE: rtl/core/mpre_pkg.sv
// Shared types and constants for the page raster engine.
// Holds the command codes, the command word carried from front to back end and the back end states.
// No dependencies.
package mpre_pkg;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_PIXEL = 3'd1,
    MODE_HLINE = 3'd2,
    MODE_DISC  = 3'd3,
    MODE_ARC   = 3'd4,
    MODE_READ  = 3'd5
  } mode_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [9:0] coord_x;
    logic signed [9:0] coord_y;
    logic signed [9:0] x_end;
    logic [5:0]        radius;
    logic              lower_half;
    logic              pixel_on;
    logic [9:0]        read_address;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SQRT,
    ST_SCAN,
    ST_RD,
    ST_MODW,
    ST_FETCH,
    ST_RDOUT
  } bk_state_t;

endpackage

FILE: rtl/core/mono_page_raster_engine.sv
// Top level of the page raster engine.
// Depends on mpre_pkg, mpre_front and mpre_back.
//
// Command words arrive on in_valid/in_ready, one field per port. A two-entry queue
// in the front end holds them while the back end rasterizes the previous word;
// unused modes are accepted and dropped. Only read words produce an output word,
// on out_valid/out_ready, carrying the addressed byte.
//
// For a read word the back end passes through ST_FETCH and ST_RDOUT, and out_valid
// is registered from ST_RDOUT. The back end takes a word in ST_IDLE, then scans
// each point in ST_SCAN and writes each on-screen pixel by a read in ST_RD and a
// write in ST_MODW; a line scans one point per column, a disc (2r+1)^2 points,
// an arc works out a six-bit square root per column in ST_SQRT and then scans two
// points, and a clear writes every store byte (1024 at the default size).
// Reset clears the store with the same pass; words queue but do not run until it
// ends. While the receiver stalls, the byte is held; the next read word waits in
// the front-end queue, which fills until in_ready drops.
module mono_page_raster_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        mode,
  input  logic signed [9:0] coord_x,
  input  logic signed [9:0] coord_y,
  input  logic signed [9:0] x_end,
  input  logic [5:0]        radius,
  input  logic              lower_half,
  input  logic              pixel_on,
  input  logic [9:0]        read_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        read_data
);
  import mpre_pkg::*;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  assign in_cmd = '{mode, coord_x, coord_y, x_end, radius, lower_half, pixel_on, read_address};
  mpre_front u_front (.*);
  mpre_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (.*);

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("output word changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid && $stable(q_cmd))
    else $error("queued word changed while waiting");

  assert property (@(posedge clk) rst |=> !out_valid && !q_valid)
    else $error("channels not empty after reset");
endmodule

FILE: rtl/core/mpre_front.sv
// Front end: accepts command words, drops unused modes, queues the rest.
// Depends on mpre_pkg.
module mpre_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mpre_pkg::cmd_t      in_cmd,
  output logic                q_valid,
  input  logic                q_ready,
  output mpre_pkg::cmd_t      q_cmd
);
  import mpre_pkg::*;

  cmd_t       slots [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;
  logic       legal;

  assign legal    = (in_cmd.mode <= MODE_READ);
  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && legal;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_cmd;
  end
endmodule

FILE: rtl/core/mpre_back.sv
// Back end: rasterizes queued commands into the page store one pixel at a time, clears it and answers reads.
// Holds the frame memory and an iterative square root unit. Depends on mpre_pkg.
module mpre_back #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  mpre_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     read_data
);
  import mpre_pkg::*;

  localparam int Pages = (SCREEN_HEIGHT + 7) / 8;
  localparam int Depth = SCREEN_WIDTH * Pages;
  localparam int AW    = $clog2(Depth);

  bk_state_t          state, state_next, walk_next;
  cmd_t               cmd;
  logic [7:0]         mem [Depth];
  logic [7:0]         rdata;
  logic [AW-1:0]      clr_cnt;
  logic signed [11:0] dx, dy;
  logic signed [11:0] rad, rad_q;
  logic [5:0]         sq_root, sq_bit, sq_trial;
  logic [13:0]        sq_trial2, sq_rem;
  logic               arc_second;
  logic signed [7:0]  dx_lo, dy_lo;
  logic signed [15:0] dx_sq, dy_sq;
  logic [13:0]        dist2, r2;
  logic signed [11:0] px, py, hy;
  logic               on_screen, in_shape, point_last, advance;
  logic [AW-1:0]      pix_addr, rd_addr, waddr;
  logic [7:0]         mask, wdata;
  logic               we;
  logic               rd_in_range;

  assign rad       = $signed({6'b0, cmd.radius});
  assign rad_q     = $signed({6'b0, q_cmd.radius});
  assign dx_lo     = dx[7:0];
  assign dy_lo     = dy[7:0];
  assign dx_sq     = dx_lo * dx_lo;
  assign dy_sq     = dy_lo * dy_lo;
  assign dist2     = dx_sq[13:0] + dy_sq[13:0];
  assign r2        = 14'(cmd.radius) * 14'(cmd.radius);
  assign sq_rem    = r2 - dx_sq[13:0];
  assign sq_trial  = sq_root | sq_bit;
  assign sq_trial2 = 14'(sq_trial) * 14'(sq_trial);
  assign hy        = $signed({6'b0, sq_root}) - $signed({11'b0, arc_second});
  assign px        = 12'(cmd.coord_x) + dx;

  always_comb begin
    py = 12'(cmd.coord_y) + dy;
    if (cmd.mode == MODE_ARC) begin
      py = cmd.lower_half ? 12'(cmd.coord_y) + hy : 12'(cmd.coord_y) - hy;
    end
  end

  assign on_screen = (px >= 12'sd0) && (px < 12'(SCREEN_WIDTH)) &&
                     (py >= 12'sd0) && (py < 12'(SCREEN_HEIGHT));
  assign pix_addr  = AW'(px[7:0]) + AW'(py[6:3]) * AW'(SCREEN_WIDTH);
  assign mask      = 8'd1 << py[2:0];
  assign rd_in_range = (14'(cmd.read_address) < 14'(Depth));

  always_comb begin
    in_shape   = 1'b1;
    point_last = 1'b1;
    case (cmd.mode)
      MODE_HLINE: begin
        in_shape   = (px <= 12'(cmd.x_end));
        point_last = (px >= 12'(cmd.x_end));
      end
      MODE_DISC: begin
        in_shape   = (dist2 <= r2);
        point_last = (dx == rad) && (dy == rad);
      end
      MODE_ARC: point_last = arc_second && (dx == rad);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    advance    = 1'b0;
    we         = 1'b0;
    waddr      = pix_addr;
    wdata      = cmd.pixel_on ? (rdata | mask) : (rdata & ~mask);
    rd_addr    = pix_addr;
    walk_next  = (cmd.mode == MODE_ARC && arc_second) ? ST_SQRT : ST_SCAN;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && !(q_cmd.mode == MODE_READ && out_valid)) begin
          q_ready = 1'b1;
          unique case (q_cmd.mode) inside
            MODE_CLEAR:                         state_next = ST_CLEAR;
            MODE_ARC:                           state_next = ST_SQRT;
            MODE_READ:                          state_next = ST_FETCH;
            MODE_PIXEL, MODE_HLINE, MODE_DISC:  state_next = ST_SCAN;
            default:                            state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = 8'd0;
        if (clr_cnt == AW'(Depth - 1)) state_next = ST_IDLE;
      end
      ST_SQRT: if (sq_bit == 6'b000001) state_next = ST_SCAN;
      ST_SCAN: begin
        if (in_shape && on_screen) begin
          state_next = ST_RD;
        end else if (!in_shape && cmd.mode == MODE_HLINE) begin
          state_next = ST_IDLE;
        end else begin
          advance    = 1'b1;
          state_next = point_last ? ST_IDLE : walk_next;
        end
      end
      ST_RD: state_next = ST_MODW;
      ST_MODW: begin
        we         = 1'b1;
        advance    = 1'b1;
        state_next = point_last ? ST_IDLE : walk_next;
      end
      ST_FETCH: begin
        rd_addr    = AW'(cmd.read_address);
        state_next = ST_RDOUT;
      end
      ST_RDOUT: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      read_data <= 8'd0;
    end else begin
      if (q_ready) clr_cnt <= '0;
      else if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      out_valid <= (state == ST_RDOUT) || (out_valid && !out_ready);
      if (state == ST_RDOUT) read_data <= rd_in_range ? rdata : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      cmd        <= q_cmd;
      dx         <= (q_cmd.mode == MODE_DISC || q_cmd.mode == MODE_ARC) ? -rad_q : 12'sd0;
      dy         <= (q_cmd.mode == MODE_DISC) ? -rad_q : 12'sd0;
      arc_second <= 1'b0;
      sq_bit     <= 6'b100000;
      sq_root    <= 6'd0;
    end else if (state == ST_SQRT) begin
      if (sq_trial2 <= sq_rem) sq_root <= sq_trial;
      sq_bit <= sq_bit >> 1;
    end else if (advance) begin
      case (cmd.mode)
        MODE_HLINE: dx <= dx + 12'sd1;
        MODE_DISC: begin
          if (dx == rad) begin
            dx <= -rad;
            dy <= dy + 12'sd1;
          end else begin
            dx <= dx + 12'sd1;
          end
        end
        MODE_ARC: begin
          if (!arc_second) begin
            arc_second <= 1'b1;
          end else begin
            arc_second <= 1'b0;
            dx         <= dx + 12'sd1;
            sq_bit     <= 6'b100000;
            sq_root    <= 6'd0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
